[rtl/mdio_clause22_bit_master_defines.svh]
// Assertion macros for the MDIO bit master RTL.
`ifndef MDIO_CLAUSE22_BIT_MASTER_DEFINES_SVH
`define MDIO_CLAUSE22_BIT_MASTER_DEFINES_SVH

`ifndef ASSERT_OFF

// Check that a property holds at every clock edge outside reset.
`define MDC22_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that an expression never becomes true outside reset.
`define MDC22_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define MDC22_ASSERT(label, clk, rst, prop, msg)
`define MDC22_NEVER(label, clk, rst, expr, msg)

`endif

`endif

[rtl/mdc22_pkg.sv]
// Types and constants of the MDIO Clause 22 bit master.
package mdc22_pkg;

  // Request kinds carried with each slot
  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  // Clause 22 opcodes
  localparam logic [1:0] OP_READ  = 2'b10;
  localparam logic [1:0] OP_WRITE = 2'b01;

  localparam int DATA_BITS   = 16;
  localparam int FLUSH_SLOTS = 32;
  localparam int ADDR_BITS   = 5;
  localparam logic [DATA_BITS-1:0] ERR_DATA = 16'hFFFF;

  // Slot offsets after the preamble
  localparam int SLOT_START0   = 0;
  localparam int SLOT_START1   = 1;
  localparam int SLOT_HDR_END  = 14;  // first slot after opcode and addresses
  localparam int HDR_TOP_BIT   = 29;  // shift bit index plus offset for header slots
  localparam int SLOT_TA       = 14;
  localparam int SLOT_TA_LOW   = 15;
  localparam int SLOT_WD_END   = SLOT_TA_LOW + 1 + DATA_BITS;   // 32
  localparam int WD_TOP_BIT    = SLOT_WD_END - 1;              // 31
  localparam int SLOT_RD_END   = SLOT_TA_LOW + DATA_BITS;      // 31
  localparam int SLOT_FLUSH_END = SLOT_TA + FLUSH_SLOTS;       // 46
  localparam int TAIL_SLOTS    = SLOT_FLUSH_END + 1;

  localparam int SHIFT_BITS = 2 + 2 * ADDR_BITS + DATA_BITS;  // 28

  typedef struct packed {
    logic [1:0]           mode;
    logic [ADDR_BITS-1:0] phy_addr;
    logic [ADDR_BITS-1:0] reg_addr;
    logic [DATA_BITS-1:0] write_data;
    logic                 line_in;
  } item_t;

  typedef struct packed {
    logic                 line_out;
    logic                 drive_enable;
    logic                 clock_pulse;
    logic                 busy_res;
    logic                 done_res;
    logic [DATA_BITS-1:0] read_data;
    logic                 turnaround_error;
  } result_t;

endpackage

[rtl/mdc22_in_reg.sv]
// Input holding register of the MDIO bit master.
module mdc22_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              drain,
  input  mdc22_pkg::item_t  item_in,
  output mdc22_pkg::item_t  item,
  output logic              valid
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (drain) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= item_in;
    end
  end

endmodule

[rtl/mdc22_seq.sv]
// Slot sequencer: transaction state and per-slot line decode.
module mdc22_seq #(
  parameter int PREAMBLE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  mdc22_pkg::item_t   item,
  output mdc22_pkg::result_t result,
  output logic               active,
  output logic [$clog2(PREAMBLE_BITS + mdc22_pkg::TAIL_SLOTS)-1:0] slot_count
);

  localparam int CW = $clog2(PREAMBLE_BITS + mdc22_pkg::TAIL_SLOTS);
  localparam int SB = mdc22_pkg::SHIFT_BITS;
  localparam int DB = mdc22_pkg::DATA_BITS;

  logic [CW-1:0] slot_count_next;
  logic          active_next;
  logic          is_write, is_write_next;
  logic [SB-1:0] out_shift, out_shift_next;
  logic [DB-1:0] in_shift, in_shift_next;
  logic          ta_failed, ta_failed_next;

  logic          start;
  logic          in_pre;
  logic [CW-1:0] rel;
  logic [4:0]    hdr_idx;
  logic [3:0]    wd_idx;
  logic          done;

  assign start   = !active && (item.mode == mdc22_pkg::MODE_READ ||
                               item.mode == mdc22_pkg::MODE_WRITE);
  assign in_pre  = slot_count < CW'(PREAMBLE_BITS);
  assign rel     = slot_count - CW'(PREAMBLE_BITS);
  assign hdr_idx = 5'(CW'(mdc22_pkg::HDR_TOP_BIT) - rel);
  assign wd_idx  = 4'(CW'(mdc22_pkg::WD_TOP_BIT) - rel);

  always_comb begin
    result           = '0;
    result.line_out  = 1'b1;
    done             = 1'b0;
    slot_count_next  = slot_count;
    active_next      = active;
    is_write_next    = is_write;
    out_shift_next   = out_shift;
    in_shift_next    = in_shift;
    ta_failed_next   = ta_failed;

    if (start) begin
      // first preamble slot of a new frame
      result.clock_pulse  = 1'b1;
      result.busy_res     = 1'b1;
      result.drive_enable = 1'b1;
      active_next     = 1'b1;
      is_write_next   = (item.mode == mdc22_pkg::MODE_WRITE);
      out_shift_next  = (item.mode == mdc22_pkg::MODE_WRITE) ?
        {mdc22_pkg::OP_WRITE, item.phy_addr, item.reg_addr, item.write_data} :
        {mdc22_pkg::OP_READ, item.phy_addr, item.reg_addr, {DB{1'b0}}};
      slot_count_next = CW'(1);
      ta_failed_next  = 1'b0;
      in_shift_next   = '0;
    end else if (active) begin
      result.clock_pulse = 1'b1;
      result.busy_res    = 1'b1;
      if (in_pre) begin
        result.drive_enable = 1'b1;
      end else if (rel == CW'(mdc22_pkg::SLOT_START0)) begin
        result.line_out     = 1'b0;
        result.drive_enable = 1'b1;
      end else if (rel == CW'(mdc22_pkg::SLOT_START1)) begin
        result.drive_enable = 1'b1;
      end else if (rel < CW'(mdc22_pkg::SLOT_HDR_END)) begin
        result.drive_enable = 1'b1;
        result.line_out     = out_shift[hdr_idx];
      end else if (is_write) begin
        if (rel == CW'(mdc22_pkg::SLOT_TA)) begin
          result.drive_enable = 1'b1;
        end else if (rel == CW'(mdc22_pkg::SLOT_TA_LOW)) begin
          result.line_out     = 1'b0;
          result.drive_enable = 1'b1;
        end else if (rel < CW'(mdc22_pkg::SLOT_WD_END)) begin
          result.drive_enable = 1'b1;
          result.line_out     = out_shift[wd_idx];
        end else begin
          done = 1'b1;
        end
      end else begin
        if (rel == CW'(mdc22_pkg::SLOT_TA)) begin
          ta_failed_next = item.line_in;
        end else if (ta_failed) begin
          if (rel >= CW'(mdc22_pkg::SLOT_FLUSH_END)) begin
            done = 1'b1;
          end
        end else if (rel < CW'(mdc22_pkg::SLOT_RD_END)) begin
          in_shift_next = {in_shift[DB-2:0], item.line_in};
        end else begin
          done = 1'b1;
        end
      end

      if (done) begin
        result.done_res = 1'b1;
        if (!is_write) begin
          result.read_data        = ta_failed ? mdc22_pkg::ERR_DATA : in_shift;
          result.turnaround_error = ta_failed;
        end
        active_next     = 1'b0;
        slot_count_next = '0;
      end else begin
        slot_count_next = slot_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      slot_count <= '0;
      is_write   <= 1'b0;
      ta_failed  <= 1'b0;
    end else if (advance) begin
      active     <= active_next;
      slot_count <= slot_count_next;
      is_write   <= is_write_next;
      ta_failed  <= ta_failed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_shift <= '0;
      in_shift  <= '0;
    end else if (advance) begin
      out_shift <= out_shift_next;
      in_shift  <= in_shift_next;
    end
  end

endmodule

[rtl/mdio_clause22_bit_master.sv]
// A slot request is held in the input register; a sequencer step then writes its result to the result register.
// Throughput: one slot request per clock cycle, sustained while the result side takes one.
// That rate is set by the single sequencer step between input and result registers.
// Reset empties both registers and returns the sequencer to idle with all state cleared.
// While a result waits untaken the input side stays ready only if the input register is empty.
`include "mdio_clause22_bit_master_defines.svh"

module mdio_clause22_bit_master #(
  parameter int PREAMBLE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // Slot request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // [4:0] phy_addr, [9:5] reg_addr, [25:10] write_data, [26] line_in, [31:27] zero
  input  logic [31:0] s_tdata,
  // [1:0] mode
  input  logic [1:0]  s_tuser,
  // Slot result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] line_out, [1] drive_enable, [2] clock_pulse, [3] busy_res, [4] done_res,
  // [20:5] read_data, [23:21] zero
  output logic [23:0] m_tdata,
  // [0] turnaround_error
  output logic [0:0]  m_tuser
);

  localparam int CW = $clog2(PREAMBLE_BITS + mdc22_pkg::TAIL_SLOTS);

  mdc22_pkg::item_t   item_in;
  mdc22_pkg::item_t   item;
  mdc22_pkg::result_t seq_result;
  mdc22_pkg::result_t out_result;
  logic               in_valid;
  logic               advance;
  logic               load;
  logic               seq_active;
  logic [CW-1:0]      slot_count;

  // Unpack the request into its fields
  assign item_in.mode       = s_tuser;
  assign item_in.phy_addr   = s_tdata[4:0];
  assign item_in.reg_addr   = s_tdata[9:5];
  assign item_in.write_data = s_tdata[25:10];
  assign item_in.line_in    = s_tdata[26];

  // Step the sequencer whenever a request is held and the result register has room this cycle
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign load     = s_tvalid && s_tready;

  mdc22_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .load    (load),
    .drain   (advance),
    .item_in (item_in),
    .item    (item),
    .valid   (in_valid)
  );

  mdc22_seq #(
    .PREAMBLE_BITS (PREAMBLE_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .item       (item),
    .result     (seq_result),
    .active     (seq_active),
    .slot_count (slot_count)
  );

  // Result register: fill on a sequencer step, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= seq_result;
    end
  end

  // Pack the result fields
  assign m_tdata = {3'b000, out_result.read_data, out_result.done_res,
                    out_result.busy_res, out_result.clock_pulse,
                    out_result.drive_enable, out_result.line_out};
  assign m_tuser = out_result.turnaround_error;

  // Hold the input side only when a request waits behind an untaken result
  `MDC22_ASSERT(a_ready_only_on_stall, clk, rst,
    !s_tready |-> (in_valid && m_tvalid && !m_tready),
    "input stalled without a pending result")

  // A turnaround error always comes with done and the all-ones read word
  `MDC22_ASSERT(a_ta_error_result, clk, rst,
    (m_tvalid && m_tuser[0]) |-> (m_tdata[4] && m_tdata[20:5] == mdc22_pkg::ERR_DATA),
    "turnaround error without done or error data")

  // The slot counter never runs past the longest frame
  `MDC22_NEVER(a_slot_bound, clk, rst,
    seq_active && (slot_count >= CW'(PREAMBLE_BITS + mdc22_pkg::TAIL_SLOTS)),
    "slot counter beyond the end of a frame")

endmodule
